>>> src/greedy_max_degree_hitting_set_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the hitting-set selector RTL.
// ----------------------------------------------------------------------------
`ifndef GREEDY_MAX_DEGREE_HITTING_SET_MACROS_SVH
`define GREEDY_MAX_DEGREE_HITTING_SET_MACROS_SVH

// Same-cycle implication, checked outside reset
`define GMDHS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define GMDHS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/gmdhs_pkg.sv
// ----------------------------------------------------------------------------
// gmdhs_pkg
// Types and constants of the greedy max-degree hitting-set selector.
// ----------------------------------------------------------------------------
package gmdhs_pkg;

	// Field widths fixed by the word format
	localparam int unsigned VERTEX_W = 10;
	localparam int unsigned COUNT_W  = 16;
	// Wide enough to hold any vertex count up to 65536
	localparam int unsigned VEXT_W   = 17;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Operation codes
	localparam logic OP_COUNT  = 1'b0;
	localparam logic OP_SELECT = 1'b1;

	// Control sequencer, one-hot
	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

endpackage

>>> src/gmdhs_mem.sv
// ----------------------------------------------------------------------------
// gmdhs_mem
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gmdhs_mem #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/greedy_max_degree_hitting_set.sv
// ----------------------------------------------------------------------------
// greedy_max_degree_hitting_set
// Greedy hitting-set selector picking the highest-degree vertex of each edge.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one vertex word per edge member:
//   operation 0 counts degrees, operation 1 runs greedy selection, and
//   last_in_edge closes the edge. Output channel (out_valid/out_ready) gives
//   a word for each unhit edge: the chosen vertex and the running count.
//   In the acceptance cycle a word issues the read of the degree and hit
//   memories; in the execute state it updates state and writes back. A
//   result word is registered as execute completes. A new word is taken only
//   once the last leaves execute; there is one read/modify/write slot.
//   After reset both memories are swept to zero, one entry per cycle, over
//   all NUM_VERTICES entries; in_ready stays low meanwhile.
//   A stalled receiver holds the result register; the next word is still
//   taken, and only a word that closes an edge with a new pick waits for
//   the register to drain.
// ----------------------------------------------------------------------------
`include "greedy_max_degree_hitting_set_macros.svh"

module greedy_max_degree_hitting_set #(
	parameter int unsigned NUM_VERTICES = 1024,
	parameter int unsigned DEGREE_BITS  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  operation,
	input  logic [gmdhs_pkg::VERTEX_W-1:0]        vertex,
	input  logic                                  last_in_edge,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  picked,
	output logic [gmdhs_pkg::VERTEX_W-1:0]        picked_vertex,
	output logic [gmdhs_pkg::COUNT_W-1:0]         solution_size
);

	localparam int unsigned AW = $clog2(NUM_VERTICES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_VERTICES - 1);
	localparam logic [gmdhs_pkg::VEXT_W-1:0] NV_EXT =
		gmdhs_pkg::VEXT_W'(NUM_VERTICES);

	gmdhs_pkg::state_t state_q;
	logic [AW-1:0] clr_q;

	// Word held between acceptance and execute
	logic                            op_s1;
	logic                            last_s1;
	logic                            valid_s1;
	logic [gmdhs_pkg::VERTEX_W-1:0]  vertex_s1;
	logic [AW-1:0]                   addr_s1;

	// Per-edge selection state
	logic                            started_q;
	logic                            edge_hit_q;
	logic [gmdhs_pkg::VERTEX_W-1:0]  best_vertex_q;
	logic [DEGREE_BITS-1:0]          best_degree_q;
	logic [gmdhs_pkg::COUNT_W-1:0]   count_q;

	// Output register
	logic                            out_valid_q;
	logic [gmdhs_pkg::VERTEX_W-1:0]  picked_vertex_q;
	logic [gmdhs_pkg::COUNT_W-1:0]   solution_size_q;

	// Memory ports
	logic                    deg_we, hit_we, mem_re;
	logic [AW-1:0]           deg_waddr, hit_waddr;
	logic [DEGREE_BITS-1:0]  deg_wdata, deg_rd;
	logic                    hit_wdata, hit_rd;

	logic [gmdhs_pkg::VEXT_W-1:0] vertex_ext, best_ext;
	logic                         accept, in_range;

	logic                            started_n, edge_hit_n;
	logic [gmdhs_pkg::VERTEX_W-1:0]  best_vertex_n;
	logic [DEGREE_BITS-1:0]          best_degree_n;
	logic [gmdhs_pkg::COUNT_W-1:0]   count_inc;
	logic                            emit, stall, exec_go;

	assign in_ready   = (state_q == gmdhs_pkg::ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign vertex_ext = {{(gmdhs_pkg::VEXT_W - gmdhs_pkg::VERTEX_W){1'b0}}, vertex};
	assign in_range   = (vertex_ext < NV_EXT);
	assign mem_re     = accept;

	// Degree and hit memories
	gmdhs_mem #(.WIDTH(DEGREE_BITS), .DEPTH(NUM_VERTICES)) u_deg_mem (
		.clk   (clk),
		.we    (deg_we),
		.waddr (deg_waddr),
		.wdata (deg_wdata),
		.re    (mem_re),
		.raddr (vertex_ext[AW-1:0]),
		.rdata (deg_rd)
	);

	gmdhs_mem #(.WIDTH(1), .DEPTH(NUM_VERTICES)) u_hit_mem (
		.clk   (clk),
		.we    (hit_we),
		.waddr (hit_waddr),
		.wdata (hit_wdata),
		.re    (mem_re),
		.raddr (vertex_ext[AW-1:0]),
		.rdata (hit_rd)
	);

	// Selection update from the read data
	always_comb begin
		started_n     = started_q;
		edge_hit_n    = edge_hit_q;
		best_vertex_n = best_vertex_q;
		best_degree_n = best_degree_q;
		if (valid_s1) begin
			if (!started_q) begin
				started_n     = 1'b1;
				edge_hit_n    = hit_rd;
				best_vertex_n = vertex_s1;
				best_degree_n = deg_rd;
			end else if (!edge_hit_q) begin
				if (hit_rd) begin
					edge_hit_n = 1'b1;
				end else if (deg_rd > best_degree_q) begin
					best_vertex_n = vertex_s1;
					best_degree_n = deg_rd;
				end
			end
		end
	end

	assign count_inc = (count_q != gmdhs_pkg::COUNT_MAX) ? count_q + 1'b1 : count_q;
	assign emit      = (op_s1 == gmdhs_pkg::OP_SELECT) && last_s1 && started_n && !edge_hit_n;
	assign stall     = emit && out_valid_q && !out_ready;
	assign exec_go   = (state_q == gmdhs_pkg::ST_EXEC) && !stall;
	assign best_ext  = {{(gmdhs_pkg::VEXT_W - gmdhs_pkg::VERTEX_W){1'b0}}, best_vertex_n};

	// Write-back: clearing sweep first, then execute
	always_comb begin
		deg_we    = 1'b0;
		deg_waddr = addr_s1;
		deg_wdata = deg_rd + 1'b1;
		hit_we    = 1'b0;
		hit_waddr = best_ext[AW-1:0];
		hit_wdata = 1'b1;
		if (state_q == gmdhs_pkg::ST_CLEAR) begin
			deg_we    = 1'b1;
			deg_waddr = clr_q;
			deg_wdata = '0;
			hit_we    = 1'b1;
			hit_waddr = clr_q;
			hit_wdata = 1'b0;
		end else if (exec_go) begin
			deg_we = (op_s1 == gmdhs_pkg::OP_COUNT) && valid_s1 && (deg_rd != '1);
			hit_we = emit;
		end
	end

	// Sequencer and clearing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gmdhs_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				gmdhs_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ADDR) begin
						state_q <= gmdhs_pkg::ST_IDLE;
					end
				end
				gmdhs_pkg::ST_IDLE: begin
					if (accept) begin
						state_q <= gmdhs_pkg::ST_EXEC;
					end
				end
				gmdhs_pkg::ST_EXEC: begin
					if (exec_go) begin
						state_q <= gmdhs_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= gmdhs_pkg::ST_CLEAR;
					clr_q   <= '0;
				end
			endcase
		end
	end

	// Accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= operation;
			last_s1   <= last_in_edge;
			valid_s1  <= in_range;
			vertex_s1 <= vertex;
			addr_s1   <= vertex_ext[AW-1:0];
		end
	end

	// Edge state and solution count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q     <= 1'b0;
			edge_hit_q    <= 1'b0;
			best_vertex_q <= '0;
			best_degree_q <= '0;
			count_q       <= '0;
		end else if (exec_go && (op_s1 == gmdhs_pkg::OP_SELECT)) begin
			best_vertex_q <= best_vertex_n;
			best_degree_q <= best_degree_n;
			started_q     <= last_s1 ? 1'b0 : started_n;
			edge_hit_q    <= last_s1 ? 1'b0 : edge_hit_n;
			if (emit) begin
				count_q <= count_inc;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go && emit) begin
			picked_vertex_q <= best_vertex_n;
			solution_size_q <= count_inc;
		end
	end

	assign out_valid     = out_valid_q;
	assign picked        = 1'b1;
	assign picked_vertex = picked_vertex_q;
	assign solution_size = solution_size_q;

	// Checks
	`GMDHS_ASSERT_NOW(a_no_accept_in_clear, state_q == gmdhs_pkg::ST_CLEAR, !in_ready,
		"word accepted during clearing sweep")
	`GMDHS_ASSERT_NEXT(a_accept_to_exec, accept, state_q == gmdhs_pkg::ST_EXEC,
		"accepted word did not reach execute")
	`GMDHS_ASSERT_NOW(a_hit_write_on_close, hit_we && state_q != gmdhs_pkg::ST_CLEAR,
		op_s1 == gmdhs_pkg::OP_SELECT && last_s1 && !stall,
		"hit written outside an edge close")
	`GMDHS_ASSERT_NOW(a_result_count_nonzero, out_valid_q, solution_size_q != '0,
		"result with zero solution size")

endmodule
